>>> sv/bmpd_pkg.sv
`timescale 1ns / 1ps

package bmpd_pkg;

  localparam int MAX_SIDE_DEF = 16384;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_ADDR_W  = $clog2(PAL_ENTRIES);
  localparam int PAL_WORD_W  = 32;

  // byte position covers the palette (4 bytes per entry) and the header
  localparam int POS_W        = PAL_ADDR_W + 2;
  localparam int HEADER_BYTES = 54;

  // header field offsets, little-endian
  localparam int POS_WIDTH  = 18;
  localparam int POS_HEIGHT = 22;
  localparam int POS_BPP    = 28;

  localparam logic [15:0] SIG_BM = 16'h4D42;
  localparam logic [15:0] BPP_8  = 16'd8;
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;

  localparam int SIDE_OUT_W = 15;
  localparam int BPP_OUT_W  = 6;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

endpackage

>>> sv/bmpd_ram.sv
`timescale 1ns / 1ps

module bmpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/bmp_stream_pixel_decoder_unit.sv
`timescale 1ns / 1ps

// Streaming BMP decoder, one file byte per transaction on the byte channel
// (data_byte, first_byte, end_of_stream under byte_valid / byte_stall).
// first_byte restarts parsing at header byte 0; end_of_stream marks the
// last byte of the file. The result channel (kind, pixel, image_width,
// image_height, bits_per_pixel, last_pixel under result_valid /
// result_stall) carries a header-accepted or reject result after the
// 54-byte header, a reject at an early end_of_stream, and one pixel word
// per completed pixel: a palette word per index byte for 8-bit files
// (after the 1024-byte palette), or the gathered bytes with bytes 0 and 2
// exchanged for 24/32-bit files. Throughput is one byte per cycle while
// result_stall is low. A byte that produces a result passes through
// stage 1, where the palette RAM read runs, and then the output register.
// When result_stall is high, the output register and the stage behind it
// fill, and byte_stall rises; no transaction is lost or repeated.
// Reset puts the parser in the header phase and empties the pipeline.
// The palette RAM is not cleared; every entry is loaded before use.
// After a finished image or a reject the parser ignores bytes until
// first_byte.

module bmp_stream_pixel_decoder_unit
  import bmpd_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  logic [7:0]            data_byte,
  input  logic                  first_byte,
  input  logic                  end_of_stream,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [1:0]            kind,
  output logic [31:0]           pixel,
  output logic [SIDE_OUT_W-1:0] image_width,
  output logic [SIDE_OUT_W-1:0] image_height,
  output logic [BPP_OUT_W-1:0]  bits_per_pixel,
  output logic                  last_pixel
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CNT_W  = 2 * SIDE_W;

  // parser state
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_pos;
  logic [15:0]        signature;
  logic [31:0]        width_reg;
  logic [31:0]        height_reg;
  logic [15:0]        bit_count;
  logic [CNT_W-1:0]   pixel_counter;
  logic [CNT_W-1:0]   total;
  logic [23:0]        pixel_asm;
  logic [1:0]         byte_in_pixel;

  // stage 1: result waiting on the palette read
  logic                  s1_valid;
  kind_t                 s1_kind;
  logic                  s1_use_ram;
  logic [31:0]           s1_word;
  logic                  s1_last;
  logic [SIDE_OUT_W-1:0] s1_width;
  logic [SIDE_OUT_W-1:0] s1_height;
  logic [BPP_OUT_W-1:0]  s1_bpp;

  logic accept, out_free, s1_adv;

  // palette RAM ports
  logic                  ram_wr_en;
  logic [PAL_ADDR_W-1:0] ram_wr_addr;
  logic [PAL_WORD_W-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [PAL_WORD_W-1:0] ram_rd_data;

  // decode of the incoming byte
  phase_t           cur_phase;
  logic [POS_W-1:0] cur_pos;
  logic             hdr_last, hdr_ok, pal_last, bc8, bc32, pix_complete, pix_last;
  logic [POS_W-1:0] off_w, off_h;

  // result of this byte
  logic        res_fire;
  kind_t       res_kind;
  logic        res_use_ram;
  logic [31:0] res_word;
  logic        res_last;

  assign out_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;
  assign accept     = byte_valid && !byte_stall;

  assign cur_phase = first_byte ? PH_HEADER : phase;
  assign cur_pos   = first_byte ? '0 : byte_pos;

  assign off_w = cur_pos - POS_W'(POS_WIDTH);
  assign off_h = cur_pos - POS_W'(POS_HEIGHT);

  assign hdr_last = (cur_pos == POS_W'(HEADER_BYTES - 1));
  assign hdr_ok   = (signature == SIG_BM) && (width_reg != '0) && (height_reg != '0) &&
                    (width_reg <= 32'(MAX_SIDE)) && (height_reg <= 32'(MAX_SIDE)) &&
                    ((bit_count == BPP_8) || (bit_count == BPP_24) ||
                     (bit_count == BPP_32));
  assign pal_last = &cur_pos;
  assign bc8      = (bit_count == BPP_8);
  assign bc32     = (bit_count == BPP_32);

  assign pix_complete = bc8 || (byte_in_pixel == 2'd3) || ((byte_in_pixel == 2'd2) && !bc32);
  assign pix_last     = ((pixel_counter + CNT_W'(1)) == total);

  // next phase
  always_comb begin
    phase_next = cur_phase;
    unique case (cur_phase)
      PH_HEADER: begin
        if (hdr_last) begin
          if (end_of_stream || !hdr_ok) phase_next = PH_IDLE;
          else if (bc8)                 phase_next = PH_PALETTE;
          else                          phase_next = PH_PIXELS;
        end else if (end_of_stream) begin
          phase_next = PH_IDLE;
        end
      end
      PH_PALETTE: begin
        if (end_of_stream) phase_next = PH_IDLE;
        else if (pal_last) phase_next = PH_PIXELS;
      end
      PH_PIXELS: begin
        if (end_of_stream || (pix_complete && pix_last)) phase_next = PH_IDLE;
      end
      PH_IDLE: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  // result of the current byte
  always_comb begin
    res_fire    = 1'b0;
    res_kind    = KIND_REJECT;
    res_use_ram = 1'b0;
    res_word    = '0;
    res_last    = 1'b0;
    unique case (cur_phase)
      PH_HEADER: begin
        if (hdr_last) begin
          res_fire = 1'b1;
          res_kind = (end_of_stream || !hdr_ok) ? KIND_REJECT : KIND_HEADER;
        end else if (end_of_stream) begin
          res_fire = 1'b1;
        end
      end
      PH_PALETTE: begin
        res_fire = end_of_stream;
      end
      PH_PIXELS: begin
        if (pix_complete) begin
          res_fire = 1'b1;
          if (end_of_stream && !pix_last) begin
            res_kind = KIND_REJECT;
          end else begin
            res_kind    = KIND_PIXEL;
            res_last    = pix_last;
            res_use_ram = bc8;
            if (byte_in_pixel == 2'd3) begin
              res_word = {data_byte, pixel_asm[7:0], pixel_asm[15:8], pixel_asm[23:16]};
            end else begin
              res_word = {8'd0, pixel_asm[7:0], pixel_asm[15:8], data_byte};
            end
          end
        end else if (end_of_stream) begin
          res_fire = 1'b1;
        end
      end
      PH_IDLE: res_fire = 1'b0;
      default: res_fire = 1'b0;
    endcase
  end

  assign ram_wr_en   = accept && (cur_phase == PH_PALETTE) && (cur_pos[1:0] == 2'd3);
  assign ram_wr_addr = cur_pos[POS_W-1:2];
  assign ram_wr_data = {data_byte, pixel_asm};
  assign ram_rd_en   = accept && (cur_phase == PH_PIXELS) && bc8;

  bmpd_ram #(
    .WIDTH (PAL_WORD_W),
    .DEPTH (PAL_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (data_byte[PAL_ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // pixel count of the image, ready long before the first pixel
  always_ff @(posedge clk) begin
    total <= CNT_W'(width_reg[SIDE_W-1:0] * height_reg[SIDE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_pos      <= '0;
      pixel_counter <= '0;
      byte_in_pixel <= '0;
    end else if (accept) begin
      phase <= phase_next;
      unique case (cur_phase)
        PH_HEADER: begin
          byte_pos <= hdr_last ? '0 : cur_pos + POS_W'(1);
          if (hdr_last) begin
            pixel_counter <= '0;
            byte_in_pixel <= '0;
          end
        end
        PH_PALETTE: begin
          byte_pos <= pal_last ? '0 : cur_pos + POS_W'(1);
          if (pal_last) begin
            pixel_counter <= '0;
            byte_in_pixel <= '0;
          end
        end
        PH_PIXELS: begin
          if (!bc8) begin
            byte_in_pixel <= pix_complete ? 2'd0 : byte_in_pixel + 2'd1;
          end
          if (res_fire && res_kind == KIND_PIXEL) begin
            pixel_counter <= pixel_counter + CNT_W'(1);
          end
        end
        PH_IDLE: byte_pos <= byte_pos;
        default: byte_pos <= byte_pos;
      endcase
    end
  end

  // header fields and pixel assembly; each byte lands in its slot once
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cur_phase == PH_HEADER) begin
        if (cur_pos < POS_W'(2)) begin
          signature[{cur_pos[0], 3'b000} +: 8] <= data_byte;
        end
        if (cur_pos >= POS_W'(POS_WIDTH) && cur_pos < POS_W'(POS_WIDTH + 4)) begin
          width_reg[{off_w[1:0], 3'b000} +: 8] <= data_byte;
        end
        if (cur_pos >= POS_W'(POS_HEIGHT) && cur_pos < POS_W'(POS_HEIGHT + 4)) begin
          height_reg[{off_h[1:0], 3'b000} +: 8] <= data_byte;
        end
        if (cur_pos == POS_W'(POS_BPP)) begin
          bit_count[7:0] <= data_byte;
        end
        if (cur_pos == POS_W'(POS_BPP + 1)) begin
          bit_count[15:8] <= data_byte;
        end
      end
      if (cur_phase == PH_PALETTE && cur_pos[1:0] != 2'd3) begin
        pixel_asm[{cur_pos[1:0], 3'b000} +: 8] <= data_byte;
      end
      if (cur_phase == PH_PIXELS && !bc8 && byte_in_pixel != 2'd3) begin
        pixel_asm[{byte_in_pixel, 3'b000} +: 8] <= data_byte;
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && res_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_fire) begin
      s1_kind    <= res_kind;
      s1_use_ram <= res_use_ram;
      s1_word    <= res_word;
      s1_last    <= res_last;
      if (res_kind == KIND_REJECT) begin
        s1_width  <= '0;
        s1_height <= '0;
        s1_bpp    <= '0;
      end else begin
        s1_width  <= width_reg[SIDE_OUT_W-1:0];
        s1_height <= height_reg[SIDE_OUT_W-1:0];
        s1_bpp    <= bit_count[BPP_OUT_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      kind           <= s1_kind;
      pixel          <= s1_use_ram ? ram_rd_data : s1_word;
      image_width    <= s1_width;
      image_height   <= s1_height;
      bits_per_pixel <= s1_bpp;
      last_pixel     <= s1_last;
    end
  end

  a_non_pixel_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind != KIND_PIXEL) |-> (pixel == '0) && !last_pixel)
    else $error("header or reject result carries pixel data");

  a_palette_only_8bit: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PALETTE) |-> (bit_count == BPP_8))
    else $error("palette phase with a bit count other than 8");

  a_read_not_stuck: assert property (@(posedge clk) disable iff (rst)
    ram_rd_en |=> s1_valid && s1_use_ram || s1_valid && (s1_kind == KIND_REJECT))
    else $error("palette read issued without a result to carry it");

  a_24bit_three_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) && (bit_count == BPP_24) |-> (byte_in_pixel != 2'd3))
    else $error("24-bit pixel gathered a fourth byte");

endmodule
